// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the stencil threshold block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, disabled while reset is high.
`define CST_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define CST_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CST_ASSERT(name, clk, rst, prop, msg)
`define CST_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

// ===== rtl/cst_pkg.sv =====
// Shared types and constants of the cross stencil threshold block.
package cst_pkg;

   // Sizing defaults for the top-level parameters
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;
   localparam int PIXEL_BITS_DEF = 8;

   // Fixed field widths
   localparam int PIXEL_W     = 8;
   localparam int COORD_W     = 10;
   localparam int CFG_W       = 11;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_PAD_W   = RSP_TDATA_W - 1 - 2 * COORD_W;

   // Register port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register reset values and dimension floor
   localparam logic [CFG_W-1:0] THRESHOLD_RESET = CFG_W'(30);
   localparam logic [CFG_W-1:0] WIDTH_RESET     = CFG_W'(6);
   localparam logic [CFG_W-1:0] HEIGHT_RESET    = CFG_W'(6);
   localparam int MIN_DIM = 3;

   // Register indexes (byte address / 4)
   typedef enum logic [1:0] {
      REG_THRESHOLD,
      REG_FRAME_WIDTH,
      REG_FRAME_HEIGHT
   } cst_reg_type;

   // Configuration handed from the register file to the datapath
   typedef struct packed {
      logic [CFG_W-1:0] threshold;
      logic [CFG_W-1:0] frame_width;
      logic [CFG_W-1:0] frame_height;
   } cst_cfg_type;

endpackage

// ===== rtl/cst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port; read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/cst_csr.sv =====
// Register file of the cross stencil threshold block behind an APB-style port.
module cst_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [cst_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [cst_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [cst_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output cst_pkg::cst_cfg_type             cfg
);
   import cst_pkg::*;

   cst_cfg_type cfg_ff;
   cst_reg_type index;
   logic        wr_en;

   assign index  = cst_reg_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // Write on the access phase; unknown addresses are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold    <= THRESHOLD_RESET;
         cfg_ff.frame_width  <= WIDTH_RESET;
         cfg_ff.frame_height <= HEIGHT_RESET;
      end else if (wr_en) begin
         unique case (index)
            REG_THRESHOLD:    cfg_ff.threshold    <= pwdata[CFG_W-1:0];
            REG_FRAME_WIDTH:  cfg_ff.frame_width  <= pwdata[CFG_W-1:0];
            REG_FRAME_HEIGHT: cfg_ff.frame_height <= pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back the stored value
   always_comb begin
      unique case (index)
         REG_THRESHOLD:    prdata = CSR_DATA_W'(cfg_ff.threshold);
         REG_FRAME_WIDTH:  prdata = CSR_DATA_W'(cfg_ff.frame_width);
         REG_FRAME_HEIGHT: prdata = CSR_DATA_W'(cfg_ff.frame_height);
         default:          prdata = '0;
      endcase
   end

endmodule

// ===== rtl/cross_stencil_threshold.sv =====
// Top level: five-point cross sum over a raster pixel stream, thresholded.
//
// Channel  Dir  Handshake            Payload
// req_*    in   tvalid/tready        tdata = pixel, tuser = frame_start
// rsp_*    out  tvalid/tready        tdata = star, center_row, center_col; tlast
// csr_*    in   APB psel/penable     threshold, frame_width, frame_height
//
// One pixel is accepted per clock unless a stalled result blocks stage one.
// Stage one holds the line-buffer read; add and compare load the output register.
// The rate is set by the line buffers: each has one read and one write per cycle.
// Reset clears the counters and the pipeline valids; line buffers are not cleared.
// A stalled result holds the output register; one more pixel may still enter.
`include "assert_macros.svh"

module cross_stencil_threshold #(
   parameter int MAX_WIDTH  = cst_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = cst_pkg::MAX_HEIGHT_DEF,
   parameter int PIXEL_BITS = cst_pkg::PIXEL_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // input stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [cst_pkg::PIXEL_W-1:0]        req_tdata,   // [7:0] pixel
   input  logic [0:0]                         req_tuser,   // [0] frame_start
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [cst_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // [0] star, [10:1] center_row,
                                                           // [20:11] center_col, rest zero
   output logic                               rsp_tlast,   // frame_done
   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [cst_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [cst_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [cst_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import cst_pkg::*;

   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT);
   localparam int HCW   = $clog2(MAX_HEIGHT + 1);
   localparam int SUM_W = PIXEL_BITS + 3;

   cst_cfg_type cfg;

   // Clamped frame size
   logic [CW-1:0]  w_lim;
   logic [HCW-1:0] h_lim;

   // Position counters
   logic [AW-1:0] col_count_ff, col_count_in;
   logic [HW-1:0] row_count_ff, row_count_in;

   // Accept-side position logic
   logic [CW-1:0]  cc;
   logic [HCW-1:0] rr;
   logic [AW-1:0]  c_cur;
   logic [HW-1:0]  r_cur;
   logic [AW-1:0]  c_right;
   logic           emit_in;
   logic           done_in;
   logic           accept;

   // Stage one: item waiting for its line-buffer data
   logic                  s1_valid_ff;
   logic [PIXEL_BITS-1:0] s1_pix_ff;
   logic [AW-1:0]         s1_col_ff;
   logic [HW-1:0]         s1_row_ff;
   logic                  s1_emit_ff;
   logic                  s1_done_ff;
   logic                  s1_adv;
   logic                  out_free;

   // Forwarding of the write that lands on the read edge
   logic                  byp_m0_ff;
   logic                  byp_m1_ff;
   logic [PIXEL_BITS-1:0] byp_pix_ff;
   logic [PIXEL_BITS-1:0] byp_mid_ff;

   // Previous-row pixels at columns c-1 and c
   logic [PIXEL_BITS-1:0] mid_left_ff;
   logic [PIXEL_BITS-1:0] mid_center_ff;

   // Line-buffer read data and stage-one values
   logic [PIXEL_BITS-1:0] mid0_rdata, mid1_rdata, up_rdata;
   logic [PIXEL_BITS-1:0] old_mid, old_up, right_pix;
   logic [SUM_W-1:0]      sum;
   logic                  star;

   // Output register
   logic                   rsp_tvalid_ff;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff;
   logic                   rsp_tlast_ff;
   logic [COORD_W-1:0]     center_row;
   logic [COORD_W-1:0]     center_col;

   cst_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // Clamp frame size to [MIN_DIM, max]
   always_comb begin
      if (32'(cfg.frame_width) < 32'(MIN_DIM)) begin
         w_lim = CW'(MIN_DIM);
      end else if (32'(cfg.frame_width) > 32'(MAX_WIDTH)) begin
         w_lim = CW'(MAX_WIDTH);
      end else begin
         w_lim = CW'(cfg.frame_width);
      end
      if (32'(cfg.frame_height) < 32'(MIN_DIM)) begin
         h_lim = HCW'(MIN_DIM);
      end else if (32'(cfg.frame_height) > 32'(MAX_HEIGHT)) begin
         h_lim = HCW'(MAX_HEIGHT);
      end else begin
         h_lim = HCW'(cfg.frame_height);
      end
   end

   // Handshake
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;

   // Place the incoming pixel and advance the counters
   always_comb begin
      logic [CW-1:0]  col_nx;
      logic [HCW-1:0] row_nx;
      cc = req_tuser[0] ? '0 : CW'(col_count_ff);
      rr = req_tuser[0] ? '0 : HCW'(row_count_ff);
      if (cc >= w_lim) begin
         cc = '0;
         rr = rr + HCW'(1);
      end
      if (rr >= h_lim) begin
         rr = '0;
      end
      c_cur   = AW'(cc);
      r_cur   = HW'(rr);
      c_right = AW'(cc + CW'(1));

      col_nx = cc + CW'(1);
      row_nx = rr;
      if (col_nx >= w_lim) begin
         col_nx = '0;
         row_nx = rr + HCW'(1);
         if (row_nx >= h_lim) begin
            row_nx = '0;
         end
      end
      col_count_in = AW'(col_nx);
      row_count_in = HW'(row_nx);

      emit_in = (rr >= HCW'(2)) && (cc >= CW'(1))
                && (({1'b0, cc} + (CW + 1)'(2)) <= {1'b0, w_lim});
      done_in = (rr == h_lim - HCW'(1)) && (cc == w_lim - CW'(2));
   end

   // Line buffers; the middle buffer is kept twice for its two read columns
   cst_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_mid0 (
      .clock (clock),
      .we    (s1_adv),
      .waddr (s1_col_ff),
      .wdata (s1_pix_ff),
      .re    (accept),
      .raddr (c_cur),
      .rdata (mid0_rdata)
   );

   cst_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_mid1 (
      .clock (clock),
      .we    (s1_adv),
      .waddr (s1_col_ff),
      .wdata (s1_pix_ff),
      .re    (accept),
      .raddr (c_right),
      .rdata (mid1_rdata)
   );

   cst_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_up (
      .clock (clock),
      .we    (s1_adv),
      .waddr (s1_col_ff),
      .wdata (old_mid),
      .re    (accept),
      .raddr (c_cur),
      .rdata (up_rdata)
   );

   // Stage one: forward the same-edge write, sum the cross, compare
   always_comb begin
      old_mid   = byp_m0_ff ? byp_pix_ff : mid0_rdata;
      old_up    = byp_m0_ff ? byp_mid_ff : up_rdata;
      right_pix = byp_m1_ff ? byp_pix_ff : mid1_rdata;
      sum = SUM_W'(old_mid) + SUM_W'(mid_center_ff) + SUM_W'(right_pix)
            + SUM_W'(old_up) + SUM_W'(s1_pix_ff);
      star       = 32'(sum) > 32'(cfg.threshold);
      center_row = COORD_W'(s1_row_ff - HW'(1));
      center_col = COORD_W'(s1_col_ff);
   end

   // Counters, stage-one valid and previous-row pixel registers
   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff  <= '0;
         row_count_ff  <= '0;
         s1_valid_ff   <= 1'b0;
         mid_left_ff   <= '0;
         mid_center_ff <= '0;
      end else begin
         if (accept) begin
            col_count_ff <= col_count_in;
            row_count_ff <= row_count_in;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            mid_left_ff   <= mid_center_ff;
            mid_center_ff <= old_mid;
         end
      end
   end

   // Stage-one payload and forwarding data
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= PIXEL_BITS'(req_tdata);
         s1_col_ff  <= c_cur;
         s1_row_ff  <= r_cur;
         s1_emit_ff <= emit_in;
         s1_done_ff <= done_in;
         byp_m0_ff  <= s1_adv && (c_cur == s1_col_ff);
         byp_m1_ff  <= s1_adv && (c_right == s1_col_ff);
         byp_pix_ff <= s1_pix_ff;
         byp_mid_ff <= old_mid;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (s1_adv && s1_emit_ff) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_emit_ff) begin
         rsp_tdata_ff <= {RSP_PAD_W'(0), center_col, center_row, star};
         rsp_tlast_ff <= s1_done_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // Checks
   `CST_ASSERT(a_fs_origin, clock, reset, (accept && req_tuser[0]) |=> (s1_col_ff == '0 && s1_row_ff == '0), "frame start did not restart at origin")
   `CST_ASSERT(a_s1_hold, clock, reset, (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_col_ff) && $stable(s1_pix_ff)), "stalled stage one item changed")
   `CST_ASSERT(a_rsp_source, clock, reset, $rose(rsp_tvalid) |-> $past(s1_valid_ff && s1_emit_ff), "result appeared without an interior item")
   `CST_ASSERT(a_no_stale_fwd, clock, reset, (accept && !s1_valid_ff) |=> (!byp_m0_ff && !byp_m1_ff), "forwarding set without a write in flight")

endmodule

// ===== sim/cross_stencil_threshold_tb.sv =====
// Self-checking testbench for the cross stencil threshold block: directed frames, then random ones.
module cross_stencil_threshold_tb;
   import cst_pkg::*;

   localparam int CYCLE_LIMIT     = 400_000;
   localparam int SETTLE_CYCLES   = 6;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_PHASES   = 20;
   localparam int KEEP_THRESHOLD  = -1;

   // One judged centre as it leaves the block
   typedef struct packed {
      logic               star;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               done;
   } star_result_t;

   // What the sender knows about each pixel it offers
   typedef struct packed {
      logic         typed;
      star_result_t res;
   } offer_t;

   // Directed stimulus row: pixel, frame start, optional threshold write, typed result
   typedef struct packed {
      logic [PIXEL_W-1:0] pix;
      logic               fs;
      int                 thr;
      logic               typed;
      star_result_t       res;
   } pixel_row_t;

   // Register setting and stream length of one random-part phase
   typedef struct packed {
      int   thr;
      int   w;
      int   h;
      int   budget;
      logic clean;
   } phase_cfg_t;

   localparam star_result_t NO_RESULT = '0;

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [PIXEL_W-1:0]     req_tdata   = '0;   // [7:0] pixel
   logic [0:0]             req_tuser   = '0;   // [0] frame_start
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;          // [0] star, [10:1] center_row, [20:11] center_col
   logic                   rsp_tlast;
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // Predictor state: line buffers, raster position, saved previous-row pixels
   logic [PIXEL_W-1:0] line_up  [MAX_WIDTH_DEF] = '{default: '0};
   logic [PIXEL_W-1:0] line_mid [MAX_WIDTH_DEF] = '{default: '0};
   int                 col_pos = 0;
   int                 row_pos = 0;
   logic [PIXEL_W-1:0] prev_left = '0;
   logic [PIXEL_W-1:0] prev_center = '0;
   logic [CFG_W-1:0]   cfg_threshold = THRESHOLD_RESET;
   logic [CFG_W-1:0]   cfg_width     = WIDTH_RESET;
   logic [CFG_W-1:0]   cfg_height    = HEIGHT_RESET;

   star_result_t pending_stars [$];
   offer_t       offered_pixels [$];

   int   errors          = 0;
   int   pixels_in       = 0;
   int   results_checked = 0;
   int   settings_run    = 0;
   int   cycles          = 0;
   int   hold_off_req    = 0;
   logic gaps_on         = 1'b1;
   logic need_fs         = 1'b0;

   // Directed frames on a 3x3 raster: all-white star, all-black with zero threshold,
   // then a run past the frame end without frame start
   pixel_row_t directed_rows [26] = '{
      '{8'd255, 1'b1, 1274, 1'b0, NO_RESULT},
      '{8'd255, 1'b0, KEEP_THRESHOLD, 1'b0, NO_RESULT},
      '{8'd255, 1'b0, KEEP_THRESHOLD, 1'b0, NO_RESULT},
      '{8'd255, 1'b0, KEEP_THRESHOLD, 1'b0, NO_RESULT},
      '{8'd255, 1'b0, KEEP_THRESHOLD, 1'b0, NO_RESULT},
      '{8'd255, 1'b0, KEEP_THRESHOLD, 1'b0, NO_RESULT},
      '{8'd255, 1'b0, KEEP_THRESHOLD, 1'b0, NO_RESULT},
      '{8'd255, 1'b0, KEEP_THRESHOLD, 1'b1, '{1'b1, 10'd1, 10'd1, 1'b1}},
      '{8'd255, 1'b0, KEEP_THRESHOLD, 1'b0, NO_RESULT},
      '{8'd0,   1'b1, 0,              1'b0, NO_RESULT},
      '{8'd0,   1'b0, KEEP_THRESHOLD, 1'b0, NO_RESULT},
      '{8'd0,   1'b0, KEEP_THRESHOLD, 1'b0, NO_RESULT},
      '{8'd0,   1'b0, KEEP_THRESHOLD, 1'b0, NO_RESULT},
      '{8'd0,   1'b0, KEEP_THRESHOLD, 1'b0, NO_RESULT},
      '{8'd0,   1'b0, KEEP_THRESHOLD, 1'b0, NO_RESULT},
      '{8'd0,   1'b0, KEEP_THRESHOLD, 1'b0, NO_RESULT},
      '{8'd0,   1'b0, KEEP_THRESHOLD, 1'b1, '{1'b0, 10'd1, 10'd1, 1'b1}},
      '{8'd0,   1'b0, KEEP_THRESHOLD, 1'b0, NO_RESULT},
      '{8'h01,  1'b0, KEEP_THRESHOLD, 1'b0, NO_RESULT},
      '{8'h80,  1'b0, KEEP_THRESHOLD, 1'b0, NO_RESULT},
      '{8'h7f,  1'b0, KEEP_THRESHOLD, 1'b0, NO_RESULT},
      '{8'hfe,  1'b0, KEEP_THRESHOLD, 1'b0, NO_RESULT},
      '{8'h02,  1'b0, KEEP_THRESHOLD, 1'b0, NO_RESULT},
      '{8'h40,  1'b0, KEEP_THRESHOLD, 1'b0, NO_RESULT},
      '{8'h55,  1'b0, KEEP_THRESHOLD, 1'b0, NO_RESULT},
      '{8'haa,  1'b0, KEEP_THRESHOLD, 1'b0, NO_RESULT}
   };

   // Out-of-range and extreme settings first, then the largest frames
   phase_cfg_t fixed_phases [5] = '{
      '{1275, 0,    1,    60, 1'b0},
      '{0,    2,    2,    60, 1'b0},
      '{2047, 7,    5,    80, 1'b0},
      '{700,  2047, 3,    1,  1'b1},
      '{640,  3,    2047, 1,  1'b1}
   };

   cross_stencil_threshold u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still pending", cycles,
                  pending_stars.size());
         $display("FAIL cross_stencil_threshold");
         $finish;
      end
   end

   function automatic int fit_dim(logic [CFG_W-1:0] v, int top);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > top) return top;
      return int'(v);
   endfunction

   // Advance the raster by one pixel; return 1 when it judges an interior centre
   function automatic logic judge_pixel(input logic [PIXEL_W-1:0] pix, input logic fs,
                                        output star_result_t res);
      int w, h, c, r, sum;
      logic [PIXEL_W-1:0] old_mid, old_up, right;
      w = fit_dim(cfg_width, MAX_WIDTH_DEF);
      h = fit_dim(cfg_height, MAX_HEIGHT_DEF);
      res = NO_RESULT;
      judge_pixel = 1'b0;
      if (fs) begin
         col_pos = 0;
         row_pos = 0;
      end
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      c = col_pos;
      r = row_pos;
      old_mid = line_mid[c];
      old_up  = line_up[c];
      right   = (c + 1 < w) ? line_mid[c + 1] : '0;
      prev_left   = prev_center;
      prev_center = old_mid;
      if (r >= 2 && c >= 1 && c + 2 <= w) begin
         sum = int'(prev_center) + int'(prev_left) + int'(right) + int'(old_up) + int'(pix);
         res.star = (sum > int'(cfg_threshold));
         res.row  = COORD_W'(r - 1);
         res.col  = COORD_W'(c);
         res.done = (r == h - 1 && c == w - 2);
         judge_pixel = 1'b1;
      end
      line_up[c]  = old_mid;
      line_mid[c] = pix;
      col_pos = c + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= h) row_pos = 0;
      end
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   // Check each result transaction and predict from each pixel transaction
   always @(posedge clock) begin : observe
      star_result_t want, res;
      offer_t       marker;
      logic         produced;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_stars.size() == 0) begin
               $error("result with nothing pending: row %0d col %0d",
                      rsp_tdata[COORD_W:1], rsp_tdata[2*COORD_W:COORD_W+1]);
               errors++;
            end else begin
               want = pending_stars.pop_front();
               check_field("star", 32'(want.star), 32'(rsp_tdata[0]));
               check_field("center_row", 32'(want.row), 32'(rsp_tdata[COORD_W:1]));
               check_field("center_col", 32'(want.col), 32'(rsp_tdata[2*COORD_W:COORD_W+1]));
               check_field("frame_done", 32'(want.done), 32'(rsp_tlast));
               check_field("tdata padding", 32'(0),
                           32'(rsp_tdata[RSP_TDATA_W-1:2*COORD_W+1]));
               results_checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            marker   = offered_pixels.pop_front();
            produced = judge_pixel(req_tdata, req_tuser[0], res);
            if (marker.typed) pending_stars.push_back(marker.res);
            else if (produced) pending_stars.push_back(res);
            pixels_in++;
         end
      end
   end

   // Result sink: short random stalls, and one long hold-off on request
   initial begin : result_sink
      int hold_seen;
      hold_seen = 0;
      forever begin
         @(posedge clock);
         if (hold_seen != hold_off_req) begin
            hold_seen = hold_off_req;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offer one pixel, possibly after a short gap, and hold it until accepted
   task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input logic fs,
                             input logic typed, input star_result_t res);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      offered_pixels.push_back('{typed, res});
      req_tvalid   <= 1'b1;
      req_tdata    <= pix;
      req_tuser[0] <= fs;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Drop valid and wait until every pixel has been taken and every result drained
   task automatic settle();
      req_tvalid <= 1'b0;
      while (offered_pixels.size() != 0 || pending_stars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input cst_reg_type idx, input logic [CFG_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * idx);
      csr_pwdata  <= {(CSR_DATA_W-CFG_W)'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_THRESHOLD:    cfg_threshold = value;
         REG_FRAME_WIDTH:  cfg_width     = value;
         REG_FRAME_HEIGHT: cfg_height    = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic csr_read_check(input cst_reg_type idx, input logic [CFG_W-1:0] want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(4 * idx);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(want)) begin
         $error("register %s: expected %0d, read %0d", idx.name(), want, csr_prdata);
         errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [PIXEL_W-1:0] rand_pixel();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return PIXEL_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Stream frames: mostly whole frames, some cut short, run on, or noisy frame starts
   task automatic run_frames(input int budget, input logic clean);
      int sent, len, w, h, kind;
      logic fs;
      sent = 0;
      w = fit_dim(cfg_width, MAX_WIDTH_DEF);
      h = fit_dim(cfg_height, MAX_HEIGHT_DEF);
      while (sent < budget) begin
         kind = clean ? 0 : $urandom_range(0, 9);
         // close the phase on a cut frame so the next setting starts mid-raster
         if (!clean && sent + w * h >= budget) kind = 7;
         case (kind)
            7:       len = $urandom_range(1, w * h - 1);
            9:       len = $urandom_range(1, 5);
            default: len = w * h;
         endcase
         for (int k = 0; k < len; k++) begin
            if (kind == 9) fs = 1'($urandom_range(0, 1));
            else fs = (k == 0 && kind != 8);
            fs = fs | need_fs;
            need_fs = 1'b0;
            send_pixel(rand_pixel(), fs, 1'b0, NO_RESULT);
         end
         sent += len;
      end
   endtask

   // Apply a new setting while idle; a wider raster must begin with a frame start
   task automatic run_phase(input int thr, input int w, input int h, input int budget,
                            input logic clean);
      logic grow;
      settle();
      grow = fit_dim(CFG_W'(w), MAX_WIDTH_DEF) > fit_dim(cfg_width, MAX_WIDTH_DEF);
      csr_write(REG_THRESHOLD, CFG_W'(thr));
      csr_write(REG_FRAME_WIDTH, CFG_W'(w));
      csr_write(REG_FRAME_HEIGHT, CFG_W'(h));
      csr_read_check(REG_THRESHOLD, CFG_W'(thr));
      csr_read_check(REG_FRAME_WIDTH, CFG_W'(w));
      csr_read_check(REG_FRAME_HEIGHT, CFG_W'(h));
      need_fs = grow;
      run_frames(budget, clean);
      settings_run++;
   endtask

   initial begin : stimulus
      int thr, w, h;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers come out of reset at their defaults
      csr_read_check(REG_THRESHOLD, THRESHOLD_RESET);
      csr_read_check(REG_FRAME_WIDTH, WIDTH_RESET);
      csr_read_check(REG_FRAME_HEIGHT, HEIGHT_RESET);
      csr_write(REG_FRAME_WIDTH, CFG_W'(MIN_DIM));
      csr_write(REG_FRAME_HEIGHT, CFG_W'(MIN_DIM));

      // Walk the directed table on the smallest raster
      foreach (directed_rows[i]) begin
         if (directed_rows[i].thr != KEEP_THRESHOLD) begin
            settle();
            csr_write(REG_THRESHOLD, CFG_W'(directed_rows[i].thr));
            settings_run++;
         end
         send_pixel(directed_rows[i].pix, directed_rows[i].fs, directed_rows[i].typed,
                    directed_rows[i].res);
      end

      foreach (fixed_phases[i])
         run_phase(fixed_phases[i].thr, fixed_phases[i].w, fixed_phases[i].h,
                   fixed_phases[i].budget, fixed_phases[i].clean);

      // Random settings; one phase holds the sink off, the last few run without gaps
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         gaps_on = (p < RANDOM_PHASES - 4);
         thr = $urandom_range(0, 1275);
         w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 14);
         h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);
         if (p == 4) hold_off_req++;
         run_phase(thr, w, h, 90, 1'b0);
      end

      settle();
      $display("Run covered %0d pixels and %0d judged centres over %0d register settings,",
               pixels_in, results_checked, settings_run);
      $display("from the 3x3 floor to the 1024 clamp in each direction, thresholds 0 to 2047.");
      if (errors == 0) begin
         $display("PASS cross_stencil_threshold");
      end else begin
         $display("FAIL cross_stencil_threshold");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/cst_pkg.sv
rtl/cst_ram.sv
rtl/cst_csr.sv
rtl/cross_stencil_threshold.sv
sim/cross_stencil_threshold_tb.sv
